### hdl/wm_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the window median block: default sizes, command
// codes and the control/status bundles between controller and datapath.
// No dependencies.
package wm_pkg;

  localparam int WM_DEPTH_DEFAULT = 128;
  localparam int WM_WIDTH_DEFAULT = 32;

  localparam int VALUE_W = 32;
  localparam int COUNT_OUT_W = 8;

  localparam logic CMD_PUSH    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic push;     // write sample_value into the store
    logic start;    // latch count and flag, empty the store, set up the first pass
    logic scan_rd;  // read the store at the scan address and advance it
    logic decide;   // settle one result bit from the finished scan
    logic pass2;    // set up the pass for the upper middle value
    logic finish;   // load the result register
  } wm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic store_empty;  // no samples held (current count)
    logic n_odd;        // latched count is odd
    logic scan_last;    // scan address is the last held entry
    logic bit_last;     // the bit being settled is bit 0
    logic second_pass;  // working on the upper middle value
    logic res_busy;     // result register full and stalled
  } wm_stat_t;

endpackage

### hdl/wm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the window median block: request handshake and the
// bit-by-bit selection walk over the store. Depends on wm_pkg.
module wm_ctrl
  import wm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  logic     command,
  input  wm_stat_t stat,
  output wm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_PUSH) begin
            cmd.push = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = stat.store_empty ? S_DONE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      // last read data lands in the counter
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!stat.bit_last) begin
          state_next = S_SCAN;
        end else if (!stat.n_odd && !stat.second_pass) begin
          cmd.pass2  = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.res_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/wm_dp.sv
`timescale 1ns / 1ps
// Datapath for the window median block: sample store, fill count, radix
// selection registers and the result register. Depends on wm_pkg.
module wm_dp
  import wm_pkg::*;
#(
  parameter int WINDOW_DEPTH = WM_DEPTH_DEFAULT,
  parameter int SAMPLE_WIDTH = WM_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wm_cmd_t                cmd,
  output wm_stat_t               stat,
  input  logic [VALUE_W-1:0]     sample_value,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [VALUE_W-1:0]     median_value,
  output logic [COUNT_OUT_W-1:0] sample_count,
  output logic                   overflowed
);

  localparam int ADDR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(WINDOW_DEPTH);
  localparam logic [SAMPLE_WIDTH-1:0] MSB_SEL = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [SAMPLE_WIDTH-1:0] store [WINDOW_DEPTH];

  logic [COUNT_W-1:0]      stored_count;
  logic                    dropped;
  logic [COUNT_W-1:0]      n_lat;
  logic                    dropped_lat;

  logic [ADDR_W-1:0]       addr;
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic                    rd_valid;
  logic [COUNT_W-1:0]      cnt;

  logic [COUNT_W-1:0]      k;
  logic                    second;
  logic [SAMPLE_WIDTH-1:0] prefix;
  logic [SAMPLE_WIDTH-1:0] bit_sel;
  logic [SAMPLE_WIDTH-1:0] mask_hi;
  logic [SAMPLE_WIDTH-1:0] sel_lo;
  logic [SAMPLE_WIDTH-1:0] sel_hi;

  logic                    match;
  logic                    take_one;
  logic [SAMPLE_WIDTH-1:0] prefix_new;
  logic [SAMPLE_WIDTH:0]   mid_sum;
  logic [SAMPLE_WIDTH-1:0] median_w;

  // entry is below the bit in question and agrees with the settled prefix
  assign match    = (((rd_data ^ prefix) & mask_hi) == '0) && ((rd_data & bit_sel) == '0);
  assign take_one = (k >= cnt);
  assign prefix_new = take_one ? (prefix | bit_sel) : prefix;

  assign mid_sum  = {1'b0, sel_lo} + {1'b0, sel_hi};
  always_comb begin
    if (n_lat == '0) begin
      median_w = '0;
    end else if (n_lat[0]) begin
      median_w = sel_lo;
    end else begin
      median_w = mid_sum[SAMPLE_WIDTH:1];
    end
  end

  assign stat.store_empty = (stored_count == '0);
  assign stat.n_odd       = n_lat[0];
  assign stat.scan_last   = (COUNT_W'(addr) == n_lat - COUNT_W'(1));
  assign stat.bit_last    = bit_sel[0];
  assign stat.second_pass = second;
  assign stat.res_busy    = res_valid && res_stall;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.push && (stored_count < DEPTH_C)) begin
      store[stored_count[ADDR_W-1:0]] <= SAMPLE_WIDTH'(sample_value);
    end
    rd_data <= store[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      dropped      <= 1'b0;
      rd_valid     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_rd;
      if (cmd.push) begin
        if (stored_count < DEPTH_C) begin
          stored_count <= stored_count + COUNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end else if (cmd.start) begin
        stored_count <= '0;
        dropped      <= 1'b0;
      end
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_lat       <= stored_count;
      dropped_lat <= dropped;
      k           <= stored_count[0] ? (stored_count >> 1)
                                     : (stored_count >> 1) - COUNT_W'(1);
      second      <= 1'b0;
    end else if (cmd.pass2) begin
      k      <= n_lat >> 1;
      second <= 1'b1;
    end else if (cmd.decide && take_one) begin
      k <= k - cnt;
    end

    if (cmd.start || cmd.pass2) begin
      prefix  <= '0;
      bit_sel <= MSB_SEL;
      mask_hi <= '0;
    end else if (cmd.decide) begin
      prefix  <= prefix_new;
      bit_sel <= bit_sel >> 1;
      mask_hi <= {1'b1, mask_hi[SAMPLE_WIDTH-1:1]};
    end

    if (cmd.decide && bit_sel[0]) begin
      if (second) begin
        sel_hi <= prefix_new;
      end else begin
        sel_lo <= prefix_new;
      end
    end

    if (cmd.start || cmd.decide) begin
      addr <= '0;
    end else if (cmd.scan_rd) begin
      addr <= addr + ADDR_W'(1);
    end

    if (cmd.start || cmd.decide) begin
      cnt <= '0;
    end else if (rd_valid && match) begin
      cnt <= cnt + COUNT_W'(1);
    end

    if (cmd.finish) begin
      median_value <= VALUE_W'(median_w);
      sample_count <= COUNT_OUT_W'(n_lat);
      overflowed   <= dropped_lat;
    end
  end

endmodule

### hdl/window_median.sv
`timescale 1ns / 1ps
// Window median: collects unsigned samples and returns their median.
// Request channel (cmd_valid/cmd_stall): command 0 pushes sample_value into
// the store, command 1 asks for the median and empties the store. Pushes
// beyond WINDOW_DEPTH are dropped and reported through overflowed.
// Result channel (res_valid/res_stall): one result per compute request with
// median_value, sample_count and overflowed; pushes give no result.
// Pushes are taken one per cycle when no compute request is in progress,
// also while a result waits to be taken. A compute request walks the store
// once per result bit, one entry a cycle through the single read port, and
// holds the request side while it runs; with an even sample count the two
// middle values are selected in turn, and an empty store skips the walk.
// The result appears as the request side is released and stays, unchanged,
// while res_stall is high; until it is taken, no further compute finishes.
// Reset (rst, synchronous) empties the store, clears the overflow flag and
// drops any pending result. Store contents need no clearing pass.
// Depends on wm_pkg, wm_ctrl and wm_dp.
module window_median
  import wm_pkg::*;
#(
  parameter int WINDOW_DEPTH = WM_DEPTH_DEFAULT,
  parameter int SAMPLE_WIDTH = WM_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  logic                   command,
  input  logic [VALUE_W-1:0]     sample_value,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [VALUE_W-1:0]     median_value,
  output logic [COUNT_OUT_W-1:0] sample_count,
  output logic                   overflowed
);

  wm_cmd_t  cmd;
  wm_stat_t stat;

  wm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .stat      (stat),
    .cmd       (cmd)
  );

  wm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample_value (sample_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .median_value (median_value),
    .sample_count (sample_count),
    .overflowed   (overflowed)
  );

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for window_median (depends on wm_pkg and window_median): directed
// table, then random push/compute runs, checked by an in-bench predictor or fixed rows.
module tb;
  import wm_pkg::*;

  localparam int DEPTH = WM_DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_DIRECTED = 25;

  typedef struct packed {
    logic [VALUE_W-1:0]     median;
    logic [COUNT_OUT_W-1:0] count;
    logic                   ovf;
  } median_rec_t;

  typedef struct packed {
    logic                   cmd;
    logic [VALUE_W-1:0]     value;
    logic                   fixed;
    logic [VALUE_W-1:0]     median;
    logic [COUNT_OUT_W-1:0] count;
    logic                   ovf;
  } step_t;

  // fixed = 1 rows carry their own expected result, the rest use the predictor
  step_t directed_steps [N_DIRECTED] = '{
    '{CMD_COMPUTE, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'd0, 1'b0},
    '{CMD_PUSH,    32'hFFFF_FFFF, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_COMPUTE, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 8'd1, 1'b0},
    '{CMD_PUSH,    32'hFFFF_FFFF, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'hFFFF_FFFF, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_COMPUTE, 32'hDEAD_BEEF, 1'b1, 32'hFFFF_FFFF, 8'd2, 1'b0},
    '{CMD_PUSH,    32'hFFFF_FFFF, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'hFFFF_FFFE, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_COMPUTE, 32'h0000_0000, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'h0000_0000, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'hFFFF_FFFF, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_COMPUTE, 32'h0000_0000, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'h0000_0005, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'h0000_0001, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'h0000_0003, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_COMPUTE, 32'h0000_0000, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'h5555_5555, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'hAAAA_AAAA, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_COMPUTE, 32'hFFFF_FFFF, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_COMPUTE, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'd0, 1'b0},
    '{CMD_PUSH,    32'h0000_0007, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'h0000_0007, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'h0000_0002, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_PUSH,    32'h0000_0009, 1'b0, 32'h0, 8'd0, 1'b0},
    '{CMD_COMPUTE, 32'h0000_0000, 1'b0, 32'h0, 8'd0, 1'b0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cmd_valid = 1'b0;
  logic                   cmd_stall;
  logic                   command = CMD_PUSH;
  logic [VALUE_W-1:0]     sample_value = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  logic [VALUE_W-1:0]     median_value;
  logic [COUNT_OUT_W-1:0] sample_count;
  logic                   overflowed;

  // predictor state
  logic [VALUE_W-1:0] held_samples [DEPTH];
  int unsigned        held_count = 0;
  logic               push_lost = 1'b0;

  median_rec_t pending_medians [$];
  median_rec_t got;
  int          failures = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  window_median dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .sample_value (sample_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .median_value (median_value),
    .sample_count (sample_count),
    .overflowed   (overflowed)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic log_fault(input string msg);
    if (failures < 10) $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    failures++;
  endtask

  function automatic median_rec_t predict_median();
    logic [VALUE_W-1:0] sorted [DEPTH];
    logic [VALUE_W-1:0] key;
    logic [VALUE_W:0]   pair_sum;
    median_rec_t        rec;
    int                 j;
    for (int i = 0; i < held_count; i++) sorted[i] = held_samples[i];
    for (int i = 1; i < held_count; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    rec.count = COUNT_OUT_W'(held_count);
    rec.ovf = push_lost;
    if (held_count == 0) begin
      rec.median = '0;
    end else if (held_count % 2 == 1) begin
      rec.median = sorted[held_count / 2];
    end else begin
      // keep the carry: the two middle values may both be near the top
      pair_sum = {1'b0, sorted[held_count/2 - 1]} + {1'b0, sorted[held_count/2]};
      rec.median = pair_sum[VALUE_W:1];
    end
    return rec;
  endfunction

  // Drive one request, wait for it to be taken, then update the predictor.
  task automatic send_request(input logic cmd, input logic [VALUE_W-1:0] value,
                              input logic fixed, input median_rec_t fixed_rec);
    median_rec_t rec;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd_valid    <= 1'b1;
    command      <= cmd;
    sample_value <= value;
    do @(posedge clk); while (cmd_stall);
    if (cmd == CMD_PUSH) begin
      if (held_count < DEPTH) begin
        held_samples[held_count] = value;
        held_count++;
      end else begin
        push_lost = 1'b1;
      end
    end else begin
      rec = predict_median();
      pending_medians.insert(pending_medians.size(), fixed ? fixed_rec : rec);
      held_count = 0;
      push_lost = 1'b0;
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return VALUE_W'($urandom_range(0, 15));
      3:       return 32'hFFFF_FFF0 | VALUE_W'($urandom_range(0, 15));
      4:       return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // result side: random stall bursts between free stretches
  always @(posedge clk) begin
    if (quiet) begin
      res_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!res_stall && $urandom_range(0, 3) == 0) begin
      res_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      res_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 20);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_medians.size() == 0) begin
        log_fault($sformatf("result with none pending: median %h count %0d ovf %0b",
                            median_value, sample_count, overflowed));
      end else begin
        got = pending_medians.pop_front();
        if (median_value !== got.median)
          log_fault($sformatf("median_value exp %h got %h", got.median, median_value));
        if (sample_count !== got.count)
          log_fault($sformatf("sample_count exp %0d got %0d", got.count, sample_count));
        if (overflowed !== got.ovf)
          log_fault($sformatf("overflowed exp %0b got %0b", got.ovf, overflowed));
      end
    end
  end

  initial begin
    int random_items;
    int run_len;
    median_rec_t no_rec;
    step_t row;
    random_items = 0;
    no_rec = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_steps[i];
      send_request(row.cmd, row.value, row.fixed, '{row.median, row.count, row.ovf});
    end

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 24))
        0:       run_len = $urandom_range(DEPTH - 2, DEPTH + 6);  // fill and overrun
        1:       run_len = 0;
        default: run_len = $urandom_range(1, 12);
      endcase
      for (int k = 0; k < run_len; k++) send_request(CMD_PUSH, pick_sample(), 1'b0, no_rec);
      send_request(CMD_COMPUTE, VALUE_W'($urandom), 1'b0, no_rec);
      random_items += run_len + 1;
      if (random_items > RANDOM_ITEMS * 4 / 5) quiet = 1'b1;
    end
    cmd_valid <= 1'b0;

    while (pending_medians.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
